// ===== hdl/swg_pkg.sv =====
package swg_pkg;

  typedef enum logic [1:0] {
    MODE_CONST,
    MODE_RAMP,
    MODE_SINE,
    MODE_SQUARE
  } mode_t;

  typedef enum logic [1:0] {
    RG_DIV,
    RG_FLAT,
    RG_ZERO
  } region_t;

  typedef struct packed {
    logic    vld;
    region_t region;
  } tag_t;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AMPLITUDE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RAMP      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PLATEAU   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT     = 3'd5;

  // Q30 unity and sine polynomial coefficients
  localparam logic [30:0] ONE30 = 31'd1073741824;
  localparam logic [30:0] COEF_A9 = 31'd172271;
  localparam int POLY_CELLS = 4;
  // entry 0 feeds the first cell of the chain
  localparam logic [POLY_CELLS-1:0][30:0] POLY_COEF = {
    31'd1686629713, 31'd693598669, 31'd85569310, 31'd5026991
  };

  // square wave edge points, multiples of Q30 unity
  localparam logic [35:0] SQ_E1  = 36'd1073741824;
  localparam logic [35:0] SQ_E19 = 36'd20401094656;
  localparam logic [35:0] SQ_E20 = 36'd21474836480;
  localparam logic [35:0] SQ_E21 = 36'd22548578304;
  localparam logic [35:0] SQ_E39 = 36'd41875931136;
  localparam logic [35:0] SQ_E40 = 36'd42949672960;

endpackage

// ===== hdl/shear_waveform_generator.sv =====
// Waveform generator: one sample time in, one waveform value out.
// Input channel sample_valid/sample_stall/sample_time carries unsigned
// fixed-point times; output channel wave_valid/wave_stall/wave_value
// returns signed fixed-point values, saturated, in input order.
// Registers are written on the cfg channel (cfg_ready is always high);
// write them only while no beat is in flight.
// Throughput: one beat per cycle while the output is not stalled. NW is
// max(2*WORD_WIDTH, WORD_WIDTH+FRAC_BITS) (64 at the defaults). At the
// core is the restoring divider, a chain of NW cells each resolving one
// quotient bit, followed by the sine polynomial cells.
// The whole pipeline moves as one: when the output beat is stalled,
// every stage holds and sample_stall rises in the same cycle.
// Reset clears all stage valid bits and loads the register defaults:
// constant mode, amplitude 1.0, ramp 1.0, plateau end all ones,
// period 40.0, period count 1.0.
module shear_waveform_generator #(
  parameter int FRAC_BITS  = 16,
  parameter int WORD_WIDTH = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              sample_valid,
  output logic                              sample_stall,
  input  logic [WORD_WIDTH-1:0]             sample_time,
  output logic                              wave_valid,
  input  logic                              wave_stall,
  output logic signed [WORD_WIDTH-1:0]      wave_value,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [swg_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [WORD_WIDTH-1:0]             cfg_data
);
  import swg_pkg::*;

  localparam int W  = WORD_WIDTH;
  localparam int F  = FRAC_BITS;
  localparam int H  = W / 2;
  localparam int NW = (2 * W > W + F) ? 2 * W : W + F;
  localparam int PW = W + 32;

  // configuration registers
  mode_t        wave_mode;
  logic [W-1:0] amplitude;
  logic [W-1:0] ramp_duration;
  logic [W-1:0] plateau_end;
  logic [W-1:0] wave_period;
  logic [W-1:0] period_count;

  logic en;
  logic periodic;
  logic [W-1:0] rdiv;
  logic [W-1:0] pdiv;
  logic [W-1:0] divisor;
  logic         neg;
  logic [W-1:0] mag;

  assign cfg_ready    = 1'b1;
  assign en           = !(wave_valid && wave_stall);
  assign sample_stall = !en;

  // register writes; unknown indexes drop
  always_ff @(posedge clk) begin
    if (rst) begin
      wave_mode     <= MODE_CONST;
      amplitude     <= W'(1) << F;
      ramp_duration <= W'(1) << F;
      plateau_end   <= '1;
      wave_period   <= W'(40) << F;
      period_count  <= W'(1) << F;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MODE:      wave_mode     <= mode_t'(cfg_data[1:0]);
        CFG_AMPLITUDE: amplitude     <= cfg_data;
        CFG_RAMP:      ramp_duration <= cfg_data;
        CFG_PLATEAU:   plateau_end   <= cfg_data;
        CFG_PERIOD:    wave_period   <= cfg_data;
        CFG_COUNT:     period_count  <= cfg_data;
        default: ;
      endcase
    end
  end

  // derived settings, stable while beats are in flight only if the user writes no register then
  always_comb begin
    periodic = (wave_mode == MODE_SINE) || (wave_mode == MODE_SQUARE);
    rdiv     = (ramp_duration == '0) ? W'(1) : ramp_duration;
    pdiv     = (wave_period == '0) ? W'(1) : wave_period;
    divisor  = periodic ? pdiv : rdiv;
    neg      = amplitude[W-1];
    mag      = neg ? (~amplitude + W'(1)) : amplitude;
  end

  // ---------------- stage 0: ramp region and partial products
  logic [W:0]       er;
  region_t          rg_c;
  logic [W-1:0]     x_c;
  logic [W+H-1:0]   plo_c;
  logic [2*W-H-1:0] phi_c;
  tag_t             s0_tag;
  logic [W-1:0]     s0_t;
  logic [W+H-1:0]   s0_plo;
  logic [2*W-H-1:0] s0_phi;

  always_comb begin
    er = {1'b0, plateau_end} + {1'b0, rdiv};
    if (sample_time <= rdiv) begin
      rg_c = RG_DIV;
      x_c  = sample_time;
    end else if (sample_time <= plateau_end) begin
      rg_c = RG_FLAT;
      x_c  = '0;
    end else if ({1'b0, sample_time} <= er) begin
      rg_c = RG_DIV;
      x_c  = W'(er - {1'b0, sample_time});
    end else begin
      rg_c = RG_ZERO;
      x_c  = '0;
    end
    plo_c = (W+H)'(mag) * (W+H)'(x_c[H-1:0]);
    phi_c = (2*W-H)'(mag) * (2*W-H)'(x_c[W-1:H]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_tag.vld <= 1'b0;
    end else if (en) begin
      s0_tag.vld <= sample_valid;
    end
    if (en) begin
      s0_tag.region <= rg_c;
      s0_t          <= sample_time;
      s0_plo        <= plo_c;
      s0_phi        <= phi_c;
    end
  end

  // ---------------- stage 1: dividend
  tag_t          s1_tag;
  logic [NW-1:0] num_c;

  always_comb begin
    if (periodic) begin
      num_c = NW'(s0_t) << F;
    end else begin
      num_c = (NW'(s0_phi) << H) + NW'(s0_plo);
    end
  end

  logic [NW-1:0] s1_num;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_tag.vld <= 1'b0;
    end else if (en) begin
      s1_tag.vld <= s0_tag.vld;
    end
    if (en) begin
      s1_tag.region <= s0_tag.region;
      s1_num        <= num_c;
    end
  end

  // ---------------- divider chain, one quotient bit per cell
  tag_t          tag_c [0:NW];
  logic [W-1:0]  rem_c [0:NW];
  logic [NW-1:0] nq_c  [0:NW];

  assign tag_c[0] = s1_tag;
  assign rem_c[0] = '0;
  assign nq_c[0]  = s1_num;

  for (genvar i = 0; i < NW; i++) begin : g_div
    swg_div_cell #(
      .DW (W),
      .NW (NW)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .divisor (divisor),
      .tag_in  (tag_c[i]),
      .rem_in  (rem_c[i]),
      .nq_in   (nq_c[i]),
      .tag_out (tag_c[i+1]),
      .rem_out (rem_c[i+1]),
      .nq_out  (nq_c[i+1])
    );
  end

  // ---------------- stage 2: phase clamp, sine argument, square shape
  logic [NW-1:0] q;
  logic [NW-1:0] pcx;
  logic [NW-1:0] phc;
  logic [29:0]   p30;
  logic [30:0]   rr;
  logic [30:0]   xs_c;
  logic [35:0]   w_c;
  logic [30:0]   sqf_c;
  logic          sqneg_c;
  logic          fneg_c;

  always_comb begin
    q    = nq_c[NW];
    pcx  = NW'(period_count);
    phc  = (q > pcx) ? pcx : q;
    p30  = 30'(phc[F-1:0]) << (30 - F);
    rr   = {1'b0, p30[27:0], 2'b00};
    xs_c = p30[28] ? (ONE30 - rr) : rr;
    w_c  = 36'(p30) * 36'd40;
    if (w_c < SQ_E1) begin
      sqf_c   = 31'(w_c);
      sqneg_c = 1'b0;
    end else if (w_c < SQ_E19) begin
      sqf_c   = ONE30;
      sqneg_c = 1'b0;
    end else if (w_c < SQ_E20) begin
      sqf_c   = 31'(SQ_E20 - w_c);
      sqneg_c = 1'b0;
    end else if (w_c < SQ_E21) begin
      sqf_c   = 31'(w_c - SQ_E20);
      sqneg_c = 1'b1;
    end else if (w_c < SQ_E39) begin
      sqf_c   = ONE30;
      sqneg_c = 1'b1;
    end else begin
      sqf_c   = 31'(SQ_E40 - w_c);
      sqneg_c = 1'b1;
    end
    fneg_c = (wave_mode == MODE_SINE) ? p30[29] : sqneg_c;
  end

  tag_t          s2_tag;
  logic [30:0]   s2_x;
  logic [PW-1:0] s2_pass;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_tag.vld <= 1'b0;
    end else if (en) begin
      s2_tag.vld <= tag_c[NW].vld;
    end
    if (en) begin
      s2_tag.region <= tag_c[NW].region;
      s2_x          <= xs_c;
      s2_pass       <= {q[W-1:0], sqf_c, fneg_c};
    end
  end

  // ---------------- stage 3: x squared
  logic [61:0]   xx;
  tag_t          s3_tag;
  logic [30:0]   s3_x;
  logic [30:0]   s3_x2;
  logic [PW-1:0] s3_pass;

  assign xx = 62'(s2_x) * 62'(s2_x);

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_tag.vld <= 1'b0;
    end else if (en) begin
      s3_tag.vld <= s2_tag.vld;
    end
    if (en) begin
      s3_tag.region <= s2_tag.region;
      s3_x          <= s2_x;
      s3_x2         <= xx[60:30];
      s3_pass       <= s2_pass;
    end
  end

  // ---------------- polynomial chain
  tag_t          ptag  [0:POLY_CELLS];
  logic [30:0]   ps    [0:POLY_CELLS];
  logic [30:0]   px    [0:POLY_CELLS];
  logic [30:0]   px2   [0:POLY_CELLS];
  logic [PW-1:0] ppass [0:POLY_CELLS];

  assign ptag[0]  = s3_tag;
  assign ps[0]    = COEF_A9;
  assign px[0]    = s3_x;
  assign px2[0]   = s3_x2;
  assign ppass[0] = s3_pass;

  for (genvar k = 0; k < POLY_CELLS; k++) begin : g_poly
    swg_poly_cell #(
      .PW (PW)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .coef     (POLY_COEF[k]),
      .tag_in   (ptag[k]),
      .s_in     (ps[k]),
      .x_in     (px[k]),
      .x2_in    (px2[k]),
      .pass_in  (ppass[k]),
      .tag_out  (ptag[k+1]),
      .s_out    (ps[k+1]),
      .x_out    (px[k+1]),
      .x2_out   (px2[k+1]),
      .pass_out (ppass[k+1])
    );
  end

  // ---------------- stage 4: final sine product, pick factor
  logic [61:0]  sx;
  logic [30:0]  sf_c;
  logic [30:0]  f_c;
  logic [PW-1:0] pend;

  always_comb begin
    pend = ppass[POLY_CELLS];
    sx   = 62'(ps[POLY_CELLS]) * 62'(px[POLY_CELLS]);
    sf_c = (sx[61:30] > 32'(ONE30)) ? ONE30 : sx[60:30];
    f_c  = (wave_mode == MODE_SINE) ? sf_c : pend[31:1];
  end

  tag_t         s4_tag;
  logic [30:0]  s4_f;
  logic         s4_fneg;
  logic [W-1:0] s4_m;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_tag.vld <= 1'b0;
    end else if (en) begin
      s4_tag.vld <= ptag[POLY_CELLS].vld;
    end
    if (en) begin
      s4_tag.region <= ptag[POLY_CELLS].region;
      s4_f          <= f_c;
      s4_fneg       <= pend[0];
      s4_m          <= pend[PW-1:32];
    end
  end

  // ---------------- stage 5: amplitude scaling with rounding
  logic [W+30:0] prod;
  logic [W+30:0] rnd;
  tag_t          s5_tag;
  logic [W:0]    s5_m2;
  logic          s5_fneg;
  logic [W-1:0]  s5_m;

  always_comb begin
    prod = (W+31)'(mag) * (W+31)'(s4_f);
    rnd  = prod + ((W+31)'(1) << 29);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_tag.vld <= 1'b0;
    end else if (en) begin
      s5_tag.vld <= s4_tag.vld;
    end
    if (en) begin
      s5_tag.region <= s4_tag.region;
      s5_m2         <= rnd[W+30:30];
      s5_fneg       <= s4_fneg;
      s5_m          <= s4_m;
    end
  end

  // ---------------- output: sign and saturate
  function automatic logic [W-1:0] sat_signed(input logic [W:0] m, input logic sgn);
    logic [W:0] lim;
    lim = (W+1)'(1) << (W - 1);
    if (sgn) begin
      sat_signed = (m >= lim) ? lim[W-1:0] : (~m[W-1:0] + W'(1));
    end else begin
      sat_signed = (m >= lim) ? (lim[W-1:0] - W'(1)) : m[W-1:0];
    end
  endfunction

  logic [W:0]   mr;
  logic [W-1:0] val_c;

  always_comb begin
    case (s5_tag.region)
      RG_DIV:  mr = {1'b0, s5_m};
      RG_FLAT: mr = {1'b0, mag};
      default: mr = '0;
    endcase
    case (wave_mode)
      MODE_CONST: val_c = amplitude;
      MODE_RAMP:  val_c = sat_signed(mr, neg && (mr != '0));
      default:    val_c = sat_signed(s5_m2, (neg != s5_fneg) && (s5_m2 != '0));
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wave_valid <= 1'b0;
    end else if (en) begin
      wave_valid <= s5_tag.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      wave_value <= val_c;
    end
  end

endmodule

// ===== hdl/swg_div_cell.sv =====
module swg_div_cell #(
  parameter int DW = 32,
  parameter int NW = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic [DW-1:0]       divisor,
  input  swg_pkg::tag_t       tag_in,
  input  logic [DW-1:0]       rem_in,
  input  logic [NW-1:0]       nq_in,
  output swg_pkg::tag_t       tag_out,
  output logic [DW-1:0]       rem_out,
  output logic [NW-1:0]       nq_out
);
  import swg_pkg::*;

  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          qbit;
  logic [DW-1:0] rem_next;
  logic [NW-1:0] nq_next;

  // bring down one numerator bit, subtract where it fits
  always_comb begin
    trial    = {rem_in, nq_in[NW-1]};
    diff     = trial - {1'b0, divisor};
    qbit     = (trial >= {1'b0, divisor});
    rem_next = qbit ? diff[DW-1:0] : trial[DW-1:0];
    nq_next  = {nq_in[NW-2:0], qbit};
  end

  // advance the beat; only the valid bit is reset
  always_ff @(posedge clk) begin
    if (rst) begin
      tag_out.vld <= 1'b0;
    end else if (en) begin
      tag_out.vld <= tag_in.vld;
    end
    if (en) begin
      tag_out.region <= tag_in.region;
      rem_out        <= rem_next;
      nq_out         <= nq_next;
    end
  end

endmodule

// ===== hdl/swg_poly_cell.sv =====
module swg_poly_cell #(
  parameter int PW = 1
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic [30:0]     coef,
  input  swg_pkg::tag_t   tag_in,
  input  logic [30:0]     s_in,
  input  logic [30:0]     x_in,
  input  logic [30:0]     x2_in,
  input  logic [PW-1:0]   pass_in,
  output swg_pkg::tag_t   tag_out,
  output logic [30:0]     s_out,
  output logic [30:0]     x_out,
  output logic [30:0]     x2_out,
  output logic [PW-1:0]   pass_out
);
  import swg_pkg::*;

  logic [61:0] prod;
  logic [30:0] s_next;

  // one Horner step: coef - s*x^2 in Q30
  always_comb begin
    prod   = 62'(s_in) * 62'(x2_in);
    s_next = coef - prod[60:30];
  end

  // advance the beat; only the valid bit is reset
  always_ff @(posedge clk) begin
    if (rst) begin
      tag_out.vld <= 1'b0;
    end else if (en) begin
      tag_out.vld <= tag_in.vld;
    end
    if (en) begin
      tag_out.region <= tag_in.region;
      s_out          <= s_next;
      x_out          <= x_in;
      x2_out         <= x2_in;
      pass_out       <= pass_in;
    end
  end

endmodule

// ===== sim/shear_waveform_generator_tb.sv =====
module shear_waveform_generator_tb;
  import swg_pkg::*;

  localparam int FRAC_BITS  = 16;
  localparam int WORD_WIDTH = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd6;
  localparam int SETTLE_CYCLES = 100;
  localparam int LONG_HOLD = 200;
  localparam int WATCHDOG_LIMIT = 5000;

  // Scoreboard: register shadow, waveform predictor and expected-value queue
  class wave_scoreboard;
    mode_t       mode;
    logic [31:0] amp, ramp, plateau, period, count;
    logic [31:0] expected_waves[$];
    int          mismatches;

    function new();
      mode = MODE_CONST;
      amp = 32'h0001_0000;
      ramp = 32'h0001_0000;
      plateau = 32'hFFFF_FFFF;
      period = 32'd40 << FRAC_BITS;
      count = 32'h0001_0000;
      mismatches = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
      case (idx)
        CFG_MODE:      mode = mode_t'(data[1:0]);
        CFG_AMPLITUDE: amp = data;
        CFG_RAMP:      ramp = data;
        CFG_PLATEAU:   plateau = data;
        CFG_PERIOD:    period = data;
        CFG_COUNT:     count = data;
        default: ;
      endcase
    endfunction

    // floor(a*b/c), all ones when the quotient overflows 64 bits
    function logic [63:0] scale_div(logic [63:0] a, logic [63:0] b, logic [63:0] c);
      logic [127:0] prod;
      prod = {64'd0, a} * {64'd0, b};
      if (prod[127:64] >= c) return '1;
      return 64'(prod / {64'd0, c});
    endfunction

    // quarter-wave odd polynomial in Q30
    function logic [63:0] sine_quarter(logic [63:0] x);
      logic [63:0] x2, s;
      x2 = (x * x) >> 30;
      s = 64'd172271;
      s = 64'd5026991 - ((s * x2) >> 30);
      s = 64'd85569310 - ((s * x2) >> 30);
      s = 64'd693598669 - ((s * x2) >> 30);
      s = 64'd1686629713 - ((s * x2) >> 30);
      s = (s * x) >> 30;
      return (s > (64'd1 << 30)) ? (64'd1 << 30) : s;
    endfunction

    function logic [31:0] saturate(logic [63:0] m, bit neg);
      logic [31:0] low;
      low = m[31:0];
      if (neg) return (m >= 64'h8000_0000) ? 32'h8000_0000 : -low;
      return (m >= 64'h8000_0000) ? 32'h7FFF_FFFF : low;
    endfunction

    function logic [31:0] predict_wave(logic [31:0] t);
      logic [31:0]  neg_amp;
      logic [63:0]  mag, r, e, m, per, ph, p, f, rr, w, one;
      logic [127:0] prod;
      bit           neg, fneg;
      one = 64'd1 << 30;
      neg = amp[31];
      neg_amp = -amp;
      mag = neg ? {32'd0, neg_amp} : {32'd0, amp};
      if (mode == MODE_CONST) return amp;
      if (mode == MODE_RAMP) begin
        r = (ramp != 0) ? {32'd0, ramp} : 64'd1;
        e = {32'd0, plateau};
        if (t <= r) m = scale_div(mag, t, r);
        else if (t <= e) m = mag;
        else if (t <= e + r) m = scale_div(mag, e + r - t, r);
        else m = 0;
        return saturate(m, neg && m != 0);
      end
      per = (period != 0) ? {32'd0, period} : 64'd1;
      ph = scale_div(t, 64'd1 << FRAC_BITS, per);
      if (ph > count) ph = count;
      p = {48'd0, ph[FRAC_BITS-1:0]} << (30 - FRAC_BITS);
      fneg = 0;
      if (mode == MODE_SINE) begin
        rr = (p & ((64'd1 << 28) - 1)) << 2;
        f = sine_quarter(p[28] ? one - rr : rr);
        fneg = p[29];
      end else begin
        w = 40 * p;
        if (w < one) f = w;
        else if (w < 19 * one) f = one;
        else if (w < 20 * one) f = 20 * one - w;
        else if (w < 21 * one) begin
          f = w - 20 * one;
          fneg = 1;
        end else if (w < 39 * one) begin
          f = one;
          fneg = 1;
        end else begin
          f = 40 * one - w;
          fneg = 1;
        end
      end
      prod = {64'd0, mag} * {64'd0, f} + (128'd1 << 29);
      m = 64'(prod >> 30);
      return saturate(m, (neg != fneg) && m != 0);
    endfunction

    function void note_sample(logic [31:0] t);
      expected_waves.push_back(predict_wave(t));
    endfunction

    function void check_wave(logic [31:0] got);
      logic [31:0] want;
      if (expected_waves.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("wave beat %h with nothing expected", got);
        return;
      end
      want = expected_waves.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("wave_value mismatch: expected %h actual %h", want, got);
      end
    endfunction
  endclass

  logic clk, rst;
  logic sample_valid, sample_stall;
  logic [WORD_WIDTH-1:0] sample_time;
  logic wave_valid, wave_stall;
  logic signed [WORD_WIDTH-1:0] wave_value;
  logic cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [WORD_WIDTH-1:0] cfg_data;

  wave_scoreboard sb;
  bit idle_on;
  bit long_hold_req;
  int rx_hold;
  int quiet_cycles;

  shear_waveform_generator #(.FRAC_BITS(FRAC_BITS), .WORD_WIDTH(WORD_WIDTH)) DUT (
    .clk(clk), .rst(rst),
    .sample_valid(sample_valid), .sample_stall(sample_stall), .sample_time(sample_time),
    .wave_valid(wave_valid), .wave_stall(wave_stall), .wave_value(wave_value),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // Check result beats and draw the next stall length
  always @(posedge clk) begin
    if (!rst && wave_valid && !wave_stall) begin
      sb.check_wave(wave_value);
      rx_hold = idle_on ? $urandom_range(0, 9) : 0;
    end
  end

  // Drive stall: per-beat holds plus one long hold on request
  initial begin
    wave_stall = 0;
    rx_hold = 0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 0;
        wave_stall = 1;
        repeat (LONG_HOLD) @(negedge clk);
      end
      if (rx_hold > 0) begin
        wave_stall = 1;
        rx_hold--;
      end else begin
        wave_stall = 0;
      end
    end
  end

  // Watchdog on cycles with no beat on any channel
  always @(posedge clk) begin
    if (rst || (sample_valid && !sample_stall) || (wave_valid && !wave_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    cfg_valid = 1;
    cfg_index = idx;
    cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_valid = 0;
  endtask

  task automatic send_sample(logic [31:0] t);
    int gap;
    gap = idle_on ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      sample_valid = 0;
      repeat (gap) @(negedge clk);
    end
    sample_valid = 1;
    sample_time = t;
    do @(posedge clk); while (sample_stall);
    sb.note_sample(t);
    @(negedge clk);
    sample_valid = 0;
  endtask

  // Hold until every expected beat has returned, then let the pipe settle
  task automatic drain();
    while (sb.expected_waves.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic logic [31:0] pick_word(bit nonzero);
    case ($urandom_range(0, 5))
      0: return nonzero ? 32'd1 : 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom;
      3: return $urandom_range(1, 32'h0010_0000);
      default: return $urandom_range(1, 32'h0100_0000);
    endcase
  endfunction

  function automatic logic [31:0] pick_amplitude();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return $urandom_range(0, 2) == 0 ? 32'd0 : 32'hFFFF_FFFF;
      3: return $urandom;
      default: return $urandom_range(0, 1) ? $urandom_range(0, 32'h0100_0000)
                                           : -$urandom_range(0, 32'h0100_0000);
    endcase
  endfunction

  // Times near the interesting points of the current shape
  function automatic logic [31:0] pick_time();
    logic [31:0] anchor;
    case ($urandom_range(0, 6))
      0: return $urandom_range(0, 1) ? 32'd0 : 32'hFFFF_FFFF;
      1, 2: return $urandom;
      3: anchor = sb.ramp;
      4: anchor = sb.plateau;
      5: anchor = sb.plateau + sb.ramp;
      default: anchor = sb.period * $urandom_range(0, 3) / 40 * $urandom_range(0, 40);
    endcase
    return anchor + $urandom_range(0, 16) - 8;
  endfunction

  logic [31:0] directed_times[4] = '{32'd0, 32'hFFFF_FFFF, 32'h0001_0000, 32'h8000_0000};

  initial begin
    sb = new();
    rst = 1;
    sample_valid = 0;
    sample_time = 0;
    cfg_valid = 0;
    cfg_index = CFG_MODE;
    cfg_data = 0;
    idle_on = 0;
    long_hold_req = 0;
    repeat (3) @(negedge clk);
    rst = 0;

    // Each mode at the reset settings, field extremes
    for (int md = 0; md < 4; md++) begin
      drain();
      write_cfg(CFG_MODE, md);
      foreach (directed_times[i]) send_sample(directed_times[i]);
    end
    // Zero ramp and period, most negative amplitude
    drain();
    write_cfg(CFG_AMPLITUDE, 32'h8000_0000);
    write_cfg(CFG_RAMP, 32'd0);
    write_cfg(CFG_PERIOD, 32'd0);
    write_cfg(CFG_COUNT, 32'hFFFF_FFFF);
    write_cfg(CFG_PLATEAU, 32'd5);
    send_sample(32'd3);
    send_sample(32'd6);
    drain();
    write_cfg(CFG_MODE, MODE_SQUARE);
    send_sample(32'd1);
    send_sample(32'hFFFF_FFFF);

    // Random phases, each with fresh register settings
    for (int phase = 0; phase < 40; phase++) begin
      drain();
      write_cfg(CFG_MODE, $urandom_range(0, 3));
      write_cfg(CFG_AMPLITUDE, pick_amplitude());
      write_cfg(CFG_RAMP, pick_word(1));
      write_cfg(CFG_PLATEAU, pick_word(0));
      write_cfg(CFG_PERIOD, pick_word(1));
      write_cfg(CFG_COUNT, $urandom_range(0, 3) == 0 ? pick_word(0)
                                                     : $urandom_range(0, 32'h0010_0000));
      if (phase % 7 == 3) write_cfg(CFG_UNUSED, $urandom);
      idle_on = ($urandom_range(0, 3) != 0);
      if (phase == 5) long_hold_req = 1;
      // the long hold phase sends more beats than the pipe holds
      for (int n = 0; n < ((phase == 5) ? 100 : 32); n++) send_sample(pick_time());
    end

    drain();
    if (sb.mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
